// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the port scan source classifier.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/psc_pkg.sv =====
// Package of the port scan source classifier: beat types, result kinds,
// opcodes, register indexes and default sizes. No dependencies.
package psc_pkg;

  localparam int MAX_SOURCES_DEF      = 32;
  localparam int PORTS_PER_SOURCE_DEF = 16;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [2:0] KIND_NEW      = 3'd0;
  localparam logic [2:0] KIND_DUP      = 3'd1;
  localparam logic [2:0] KIND_SAT      = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_LIKELY   = 3'd4;
  localparam logic [2:0] KIND_POSSIBLE = 3'd5;
  localparam logic [2:0] KIND_EMPTY    = 3'd6;

  localparam logic CFG_LIKELY   = 1'b0;
  localparam logic CFG_POSSIBLE = 1'b1;

  localparam logic [4:0] LIKELY_RESET   = 5'd8;
  localparam logic [4:0] POSSIBLE_RESET = 5'd4;

  // Operand select of the shared match unit.
  localparam logic MATCH_SRC  = 1'b0;
  localparam logic MATCH_PORT = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] src_address;
    logic [15:0] dest_port;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] reported_address;
    logic [4:0]  port_count;
    logic        last;
  } out_item_t;

endpackage

// ===== hdl/port_scan_source_classifier.sv =====
// Port scan source classifier: one entry compared per cycle by a shared match unit,
// except while a report waits on a stalled output. Record: a serial search of the
// sources, then a serial search of the ports of the matching source.
// Report: a scan of the sources in use, plus stalls on the output.
// Reset (async, active low) clears the source count and all handshake state and sets
// the thresholds to 8 and 4; stored addresses and ports are never cleared.
`include "assert_macros.svh"

module port_scan_source_classifier #(
  parameter int MaxSources     = psc_pkg::MAX_SOURCES_DEF,
  parameter int PortsPerSource = psc_pkg::PORTS_PER_SOURCE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  psc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output psc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [4:0]         cfg_data_i
);

  localparam int IdxW  = $clog2(MaxSources + 1);
  localparam int SaW   = MaxSources > 1 ? $clog2(MaxSources) : 1;
  localparam int CntW  = $clog2(PortsPerSource + 1);
  localparam int CmpW  = CntW > 5 ? CntW : 5;
  localparam int PDep  = MaxSources * PortsPerSource;
  localparam int PaW   = PDep > 1 ? $clog2(PDep) : 1;
  localparam int BaseW = $clog2(PDep + 1);
  localparam int SrcW  = 32 + CntW;

  localparam logic [CntW-1:0]  CntFull = CntW'(PortsPerSource);
  localparam logic [IdxW-1:0]  SrcFull = IdxW'(MaxSources);
  localparam logic [BaseW-1:0] BaseInc = BaseW'(PortsPerSource);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRC   = 3'd1;
  localparam logic [2:0] ST_PORT  = 3'd2;
  localparam logic [2:0] ST_RPT   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  function automatic logic [4:0] cnt5(input logic [CntW-1:0] c);
    logic [CmpW-1:0] e;
    e = CmpW'(c);
    return e[4:0];
  endfunction

  logic [2:0]         state_q, state_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [IdxW-1:0]    used_q, used_d;
  logic [CntW-1:0]    pidx_q, pidx_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [BaseW-1:0]   base_q, base_d;
  logic [31:0]        key_q;
  logic [15:0]        port_q;
  psc_pkg::out_item_t pend_q, pend_d;
  logic               pend_valid_q, pend_valid_d;
  psc_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [4:0]         likely_q, possible_q;

  logic               accept;
  logic               out_load;
  logic               match_sel;
  logic               match_eq;

  logic               src_we;
  logic [SaW-1:0]     src_waddr;
  logic [SrcW-1:0]    src_wdata;
  logic [SrcW-1:0]    src_rdata;
  logic [31:0]        src_addr_rd;
  logic [CntW-1:0]    src_cnt_rd;

  logic               port_we;
  logic [BaseW-1:0]   port_wa_full;
  logic [BaseW-1:0]   port_ra_full;
  logic [PaW-1:0]     port_waddr;
  logic [15:0]        port_rdata;

  logic               likely_hit;
  logic               possible_hit;
  logic [2:0]         rpt_kind;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_load    = !out_valid_q || !out_stall_i;
  // take threshold writes only between items
  assign cfg_ready_o = (state_q == ST_IDLE);

  assign src_addr_rd = src_rdata[SrcW-1 -: 32];
  assign src_cnt_rd  = src_rdata[CntW-1:0];

  assign likely_hit   = CmpW'(src_cnt_rd) >= CmpW'(likely_q);
  assign possible_hit = CmpW'(src_cnt_rd) >= CmpW'(possible_q);
  assign rpt_kind     = likely_hit ? psc_pkg::KIND_LIKELY : psc_pkg::KIND_POSSIBLE;

  assign port_wa_full = base_q + BaseW'(cnt_q);
  assign port_ra_full = base_q + BaseW'(pidx_d);

  psc_ram #(
    .Width(SrcW),
    .Depth(MaxSources)
  ) u_src_ram (
    .clk_i  (clk_i),
    .we_i   (src_we),
    .waddr_i(src_waddr),
    .wdata_i(src_wdata),
    .raddr_i(idx_d[SaW-1:0]),
    .rdata_o(src_rdata)
  );

  psc_ram #(
    .Width(16),
    .Depth(PDep)
  ) u_port_ram (
    .clk_i  (clk_i),
    .we_i   (port_we),
    .waddr_i(port_waddr),
    .wdata_i(port_q),
    .raddr_i(port_ra_full[PaW-1:0]),
    .rdata_o(port_rdata)
  );

  psc_match u_match (
    .sel_i      (match_sel),
    .src_word_i (src_addr_rd),
    .port_word_i(port_rdata),
    .key_addr_i (key_q),
    .key_port_i (port_q),
    .eq_o       (match_eq)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    used_d       = used_q;
    pidx_d       = pidx_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    match_sel    = psc_pkg::MATCH_SRC;
    src_we       = 1'b0;
    src_waddr    = idx_q[SaW-1:0];
    src_wdata    = {key_q, CntW'(1)};
    port_we      = 1'b0;
    port_waddr   = port_wa_full[PaW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d        = '0;
          base_d       = '0;
          pidx_d       = '0;
          pend_valid_d = 1'b0;
          state_d      = (in_data_i.opcode == psc_pkg::OP_REPORT) ? ST_RPT : ST_SRC;
        end
      end
      ST_SRC: begin
        match_sel = psc_pkg::MATCH_SRC;
        if (idx_q >= used_q) begin
          pend_valid_d = 1'b1;
          state_d      = ST_FLUSH;
          if (used_q >= SrcFull) begin
            pend_d = '{psc_pkg::KIND_FULL, key_q, 5'd0, 1'b1};
          end else begin
            // allocate the next free entry and store the first port
            src_we     = 1'b1;
            port_we    = 1'b1;
            port_waddr = base_q[PaW-1:0];
            used_d     = used_q + 1'b1;
            pend_d     = '{psc_pkg::KIND_NEW, key_q, cnt5(CntW'(1)), 1'b1};
          end
        end else if (match_eq) begin
          cnt_d   = src_cnt_rd;
          pidx_d  = '0;
          state_d = ST_PORT;
        end else begin
          idx_d  = idx_q + 1'b1;
          base_d = base_q + BaseInc;
        end
      end
      ST_PORT: begin
        match_sel = psc_pkg::MATCH_PORT;
        if (pidx_q >= cnt_q) begin
          pend_valid_d = 1'b1;
          state_d      = ST_FLUSH;
          if (cnt_q >= CntFull) begin
            pend_d = '{psc_pkg::KIND_SAT, key_q, cnt5(cnt_q), 1'b1};
          end else begin
            port_we   = 1'b1;
            src_we    = 1'b1;
            src_wdata = {key_q, cnt_q + 1'b1};
            pend_d    = '{psc_pkg::KIND_NEW, key_q, cnt5(cnt_q + 1'b1), 1'b1};
          end
        end else if (match_eq) begin
          pend_valid_d = 1'b1;
          pend_d       = '{psc_pkg::KIND_DUP, key_q, cnt5(cnt_q), 1'b1};
          state_d      = ST_FLUSH;
        end else begin
          pidx_d = pidx_q + 1'b1;
        end
      end
      ST_RPT: begin
        if (idx_q >= used_q) begin
          state_d = ST_FLUSH;
          if (pend_valid_q) begin
            pend_d.last = 1'b1;
          end else begin
            pend_valid_d = 1'b1;
            pend_d       = '{psc_pkg::KIND_EMPTY, 32'd0, 5'd0, 1'b1};
          end
        end else if (!(likely_hit || possible_hit)) begin
          idx_d = idx_q + 1'b1;
        end else if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_d       = '{rpt_kind, src_addr_rd, cnt5(src_cnt_rd), 1'b0};
          idx_d        = idx_q + 1'b1;
        end else if (out_load) begin
          // send the held beat, keep this one until the next hit or the end
          out_d       = pend_q;
          out_valid_d = 1'b1;
          pend_d      = '{rpt_kind, src_addr_rd, cnt5(src_cnt_rd), 1'b0};
          idx_d       = idx_q + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (out_load) begin
          out_d        = pend_q;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      used_q       <= '0;
      pidx_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      likely_q     <= psc_pkg::LIKELY_RESET;
      possible_q   <= psc_pkg::POSSIBLE_RESET;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      used_q       <= used_d;
      pidx_q       <= pidx_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          psc_pkg::CFG_LIKELY:   likely_q   <= cfg_data_i;
          psc_pkg::CFG_POSSIBLE: possible_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    base_q <= base_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    if (accept) begin
      key_q  <= in_data_i.src_address;
      port_q <= in_data_i.dest_port;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_used_bound, clk_i, rst_ni, used_q <= SrcFull,
                 "source count past table size")
  `ASSERT_IMPLIES(a_port_scan_ok, clk_i, rst_ni, state_q == ST_PORT,
                  (cnt_q <= CntFull) && (idx_q < used_q), "port search on bad entry")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, state_q != ST_IDLE,
               "sequencer idle after accept")
  `ASSERT_IMPLIES(a_flush_held, clk_i, rst_ni, state_q == ST_FLUSH,
                  pend_valid_q && pend_q.last, "final beat missing")

endmodule

// ===== hdl/psc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
module psc_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/psc_match.sv =====
// Shared equality unit of the classifier: compares a stored source address
// or a stored port against the key of the item. Uses psc_pkg.
module psc_match (
  input  logic        sel_i,
  input  logic [31:0] src_word_i,
  input  logic [15:0] port_word_i,
  input  logic [31:0] key_addr_i,
  input  logic [15:0] key_port_i,
  output logic        eq_o
);

  logic [31:0] op_a;
  logic [31:0] op_b;

  always_comb begin
    case (sel_i)
      psc_pkg::MATCH_PORT: begin
        op_a = {16'd0, port_word_i};
        op_b = {16'd0, key_port_i};
      end
      default: begin
        op_a = src_word_i;
        op_b = key_addr_i;
      end
    endcase
  end

  assign eq_o = (op_a == op_b);

endmodule

// ===== verif/port_scan_source_classifier_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for port_scan_source_classifier: a directed table, then random
// record and report beats, scored against an in-bench source/port tracker.
// Depends on psc_pkg and the classifier RTL only.
module port_scan_source_classifier_test;

  localparam int MAX_SRC       = psc_pkg::MAX_SOURCES_DEF;
  localparam int PORTS         = psc_pkg::PORTS_PER_SOURCE_DEF;
  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = MAX_SRC + PORTS + 4;
  localparam int LONG_HOLD     = 300;
  localparam int POOL          = 36;
  localparam int PHASE_ITEMS   = 160;
  localparam longint LIMIT_CYCLES = 600000;

  typedef enum logic [1:0] {ROW_ITEM, ROW_LIKELY, ROW_POSSIBLE} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    psc_pkg::in_item_t  item;
    logic [4:0]         value;
    logic               typed;
    psc_pkg::out_item_t want;
  } stim_row_t;

  localparam psc_pkg::in_item_t  REPORT_ITEM = '{psc_pkg::OP_REPORT, 32'h0, 16'h0};
  localparam psc_pkg::out_item_t NO_WANT     = '0;
  localparam psc_pkg::out_item_t EMPTY_BEAT  = '{psc_pkg::KIND_EMPTY, 32'h0, 5'd0, 1'b1};

  localparam stim_row_t DIR_ROWS [20] = '{
    '{ROW_ITEM, REPORT_ITEM, 5'd0, 1'b1, EMPTY_BEAT},
    '{ROW_ITEM, '{psc_pkg::OP_RECORD, 32'h0, 16'h0}, 5'd0, 1'b1,
      '{psc_pkg::KIND_NEW, 32'h0, 5'd1, 1'b1}},
    '{ROW_ITEM, '{psc_pkg::OP_RECORD, 32'h0, 16'h0}, 5'd0, 1'b1,
      '{psc_pkg::KIND_DUP, 32'h0, 5'd1, 1'b1}},
    '{ROW_ITEM, '{psc_pkg::OP_RECORD, 32'hFFFF_FFFF, 16'hFFFF}, 5'd0, 1'b1,
      '{psc_pkg::KIND_NEW, 32'hFFFF_FFFF, 5'd1, 1'b1}},
    '{ROW_ITEM, '{psc_pkg::OP_RECORD, 32'hFFFF_FFFF, 16'h0}, 5'd0, 1'b1,
      '{psc_pkg::KIND_NEW, 32'hFFFF_FFFF, 5'd2, 1'b1}},
    '{ROW_ITEM, '{psc_pkg::OP_RECORD, 32'hFFFF_FFFF, 16'hFFFF}, 5'd0, 1'b1,
      '{psc_pkg::KIND_DUP, 32'hFFFF_FFFF, 5'd2, 1'b1}},
    '{ROW_ITEM, '{psc_pkg::OP_RECORD, 32'hA5A5_5A5A, 16'h5A5A}, 5'd0, 1'b0, NO_WANT},
    // counts 1, 2, 1 sit below the reset thresholds
    '{ROW_ITEM, REPORT_ITEM, 5'd0, 1'b1, EMPTY_BEAT},
    '{ROW_POSSIBLE, REPORT_ITEM, 5'd1, 1'b0, NO_WANT},
    '{ROW_LIKELY, REPORT_ITEM, 5'd2, 1'b0, NO_WANT},
    '{ROW_ITEM, REPORT_ITEM, 5'd0, 1'b0, NO_WANT},
    '{ROW_LIKELY, REPORT_ITEM, 5'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, REPORT_ITEM, 5'd0, 1'b0, NO_WANT},
    // possible above likely: likely wins
    '{ROW_POSSIBLE, REPORT_ITEM, 5'd16, 1'b0, NO_WANT},
    '{ROW_LIKELY, REPORT_ITEM, 5'd2, 1'b0, NO_WANT},
    '{ROW_ITEM, REPORT_ITEM, 5'd0, 1'b0, NO_WANT},
    '{ROW_LIKELY, REPORT_ITEM, 5'd31, 1'b0, NO_WANT},
    '{ROW_POSSIBLE, REPORT_ITEM, 5'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, REPORT_ITEM, 5'd0, 1'b0, NO_WANT},
    '{ROW_ITEM, '{psc_pkg::OP_RECORD, 32'h5A5A_A5A5, 16'hA5A5}, 5'd0, 1'b0, NO_WANT}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  psc_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  psc_pkg::out_item_t out_data_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [4:0]         cfg_data_i;

  // tracker state
  logic [31:0] src_tab [MAX_SRC];
  logic [15:0] port_tab [MAX_SRC][PORTS];
  int unsigned port_cnt [MAX_SRC];
  int unsigned srcs_used;
  logic [4:0]  likely_thr;
  logic [4:0]  possible_thr;

  psc_pkg::out_item_t awaited_results [$];
  psc_pkg::out_item_t want_beat;
  logic [31:0]        addr_pool [POOL];
  int                 bad_results;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 holds_asked;
  int                 holds_served;
  int                 hold_left;

  port_scan_source_classifier i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("port_scan_source_classifier_test: done, errors");
    $finish;
  end

  function automatic psc_pkg::out_item_t make_beat(logic [2:0] kind, logic [31:0] addr,
                                                   int unsigned cnt, logic last);
    psc_pkg::out_item_t b;
    b.result_kind      = kind;
    b.reported_address = addr;
    b.port_count       = cnt[4:0];
    b.last             = last;
    return b;
  endfunction

  // Update the tracker with one accepted beat and return the results it causes.
  function automatic void classify_item(input psc_pkg::in_item_t it,
                                        ref psc_pkg::out_item_t res[$]);
    int                 slot;
    bit                 listed;
    psc_pkg::out_item_t tail;
    res.delete();
    if (it.opcode == psc_pkg::OP_RECORD) begin
      slot = -1;
      for (int i = 0; i < srcs_used; i++)
        if (slot < 0 && src_tab[i] == it.src_address) slot = i;
      if (slot < 0 && srcs_used >= MAX_SRC) begin
        res.push_back(make_beat(psc_pkg::KIND_FULL, it.src_address, 0, 1'b1));
        return;
      end
      if (slot < 0) begin
        slot = srcs_used;
        srcs_used++;
        src_tab[slot]  = it.src_address;
        port_cnt[slot] = 0;
      end
      listed = 1'b0;
      for (int k = 0; k < port_cnt[slot]; k++)
        if (port_tab[slot][k] == it.dest_port) listed = 1'b1;
      if (listed) begin
        res.push_back(make_beat(psc_pkg::KIND_DUP, it.src_address, port_cnt[slot], 1'b1));
      end else if (port_cnt[slot] >= PORTS) begin
        res.push_back(make_beat(psc_pkg::KIND_SAT, it.src_address, port_cnt[slot], 1'b1));
      end else begin
        port_tab[slot][port_cnt[slot]] = it.dest_port;
        port_cnt[slot]++;
        res.push_back(make_beat(psc_pkg::KIND_NEW, it.src_address, port_cnt[slot], 1'b1));
      end
    end else begin
      for (int i = 0; i < srcs_used; i++) begin
        if (port_cnt[i] >= likely_thr)
          res.push_back(make_beat(psc_pkg::KIND_LIKELY, src_tab[i], port_cnt[i], 1'b0));
        else if (port_cnt[i] >= possible_thr)
          res.push_back(make_beat(psc_pkg::KIND_POSSIBLE, src_tab[i], port_cnt[i], 1'b0));
      end
      if (res.size() == 0) begin
        res.push_back(EMPTY_BEAT);
      end else begin
        tail = res.pop_back();
        tail.last = 1'b1;
        res.push_back(tail);
      end
    end
  endfunction

  function automatic logic [4:0] pick_threshold();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return 5'd0;
    if (sel < 40) return 5'd16;
    if (sel < 45) return 5'd31;
    return 5'($urandom_range(0, 16));
  endfunction

  // Half the time revisit a few busy sources so their lists fill; the rest spreads over
  // the pool and fresh addresses, which overflow the table.
  function automatic psc_pkg::in_item_t rand_item();
    psc_pkg::in_item_t it;
    int                sel;
    it.opcode      = ($urandom_range(99) < 8) ? psc_pkg::OP_REPORT : psc_pkg::OP_RECORD;
    it.src_address = $urandom;
    it.dest_port   = 16'($urandom_range(0, 65535));
    sel = $urandom_range(99);
    if (sel < 50) it.src_address = addr_pool[$urandom_range(0, 5)];
    else if (sel < 90) it.src_address = addr_pool[$urandom_range(0, POOL - 1)];
    sel = $urandom_range(99);
    if (sel < 60) it.dest_port = 16'($urandom_range(0, 23));
    else if (sel < 65) it.dest_port = 16'h0000;
    else if (sel < 70) it.dest_port = 16'hFFFF;
    return it;
  endfunction

  // Leaves valid high with the accepted beat; the next call replaces or lowers it.
  task automatic send_item(input psc_pkg::in_item_t it, input logic typed,
                           input psc_pkg::out_item_t want);
    psc_pkg::out_item_t res [$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    classify_item(it, res);
    if (typed) awaited_results.push_back(want);
    else foreach (res[k]) awaited_results.push_back(res[k]);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == psc_pkg::CFG_LIKELY) likely_thr = val;
    else possible_thr = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: unexpected beat kind %0d addr %h count %0d last %b", $realtime,
                   out_data_o.result_kind, out_data_o.reported_address,
                   out_data_o.port_count, out_data_o.last);
      end else begin
        want_beat = awaited_results.pop_front();
        if (want_beat.result_kind !== out_data_o.result_kind ||
            want_beat.reported_address !== out_data_o.reported_address ||
            want_beat.port_count !== out_data_o.port_count ||
            want_beat.last !== out_data_o.last) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: want kind %0d addr %h count %0d last %b, got %0d %h %0d %b",
                     $realtime, want_beat.result_kind, want_beat.reported_address,
                     want_beat.port_count, want_beat.last, out_data_o.result_kind,
                     out_data_o.reported_address, out_data_o.port_count, out_data_o.last);
        end
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= psc_pkg::CFG_LIKELY;
    cfg_data_i   <= '0;
    likely_thr    = psc_pkg::LIKELY_RESET;
    possible_thr  = psc_pkg::POSSIBLE_RESET;
    srcs_used     = 0;
    bad_results   = 0;
    holds_asked   = 0;
    holds_served  = 0;
    hold_left     = 0;
    send_idle_pct = 12;
    recv_idle_pct = 63;
    foreach (addr_pool[p]) addr_pool[p] = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[r]) begin
      case (DIR_ROWS[r].kind)
        ROW_ITEM: send_item(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].want);
        ROW_LIKELY: begin
          settle();
          write_reg(psc_pkg::CFG_LIKELY, DIR_ROWS[r].value);
        end
        default: begin
          settle();
          write_reg(psc_pkg::CFG_POSSIBLE, DIR_ROWS[r].value);
        end
      endcase
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          settle();
          write_reg(psc_pkg::CFG_LIKELY, pick_threshold());
          write_reg(psc_pkg::CFG_POSSIBLE, pick_threshold());
        end
        // hold the output long enough that the input backs up
        if (n == 80) holds_asked++;
        send_item(rand_item(), 1'b0, NO_WANT);
      end
    end

    settle();
    if (bad_results == 0 && awaited_results.size() == 0) begin
      $display("port_scan_source_classifier_test: done, clean");
    end else begin
      $display("port_scan_source_classifier_test: done, errors");
    end
    $finish;
  end

endmodule
